@@ hw/rtl/brf_pkg.sv @@
// Shared operation codes and cell command types for the byte ring FIFO with search.
package brf_pkg;

  localparam logic [2:0] MODE_WRITE       = 3'd0;
  localparam logic [2:0] MODE_READ        = 3'd1;
  localparam logic [2:0] MODE_PEEK        = 3'd2;
  localparam logic [2:0] MODE_SEARCH      = 3'd3;
  localparam logic [2:0] MODE_DROP_UNTIL  = 3'd4;
  localparam logic [2:0] MODE_DROP_COUNT  = 3'd5;
  localparam logic [2:0] MODE_CLEAR       = 3'd6;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT,
    CELL_ROTATE,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [7:0]  wdata;
  } cell_cmd_t;

endpackage

@@ hw/rtl/brf_cell.sv @@
// One storage cell of the queue chain: holds a byte and its valid flag.
module brf_cell
  import brf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  logic [7:0] head_data,
  input  logic       left_valid,
  input  logic [7:0] right_data,
  input  logic       right_valid,
  output logic [7:0] data_o,
  output logic       valid_o
);

  logic [7:0] data_r, data_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    case (cmd.op)
      CELL_WRITE: begin
        if (!valid_r && left_valid) begin
          data_nxt  = cmd.wdata;
          valid_nxt = 1'b1;
        end
      end
      CELL_SHIFT: begin
        data_nxt  = right_data;
        valid_nxt = right_valid;
      end
      CELL_ROTATE: begin
        // The last held word takes the head word; the others move one place forward.
        if (right_valid) begin
          data_nxt = right_data;
        end else if (valid_r) begin
          data_nxt = head_data;
        end
      end
      CELL_CLEAR: begin
        data_nxt  = 8'd0;
        valid_nxt = 1'b0;
      end
      default: begin
        data_nxt  = data_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r  <= 8'd0;
      valid_r <= 1'b0;
    end else begin
      data_r  <= data_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign data_o  = data_r;
  assign valid_o = valid_r;

endmodule

@@ hw/rtl/byte_ring_fifo_with_search_top.sv @@
// Top level: byte queue built as a chain of cells, with search and discard control.
// Write, read, peek, clear, the unused mode, an empty search and a zero discard give their
// result word in the cycle after acceptance: one word per cycle unless the output stalls.
// A search rotates the chain once around over the held bytes; a discard until byte then shifts
// out the bytes before the match; a discard of C bytes shifts out C bytes, at most all held.
// Input stalls while an item is in work. Reset (synchronous, active low) zeroes every cell.
module byte_ring_fifo_with_search_top
  import brf_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_mode,
  input  logic [7:0] in_data_byte,
  input  logic [8:0] in_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_out,
  output logic       out_accepted,
  output logic       out_found,
  output logic [8:0] out_position_or_count,
  output logic [8:0] out_fill_level,
  output logic       out_full_res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 9) ? CW : 9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DROP
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic [CW-1:0] target_r, target_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic        found_r, found_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  dout_r, dout_nxt;
  logic        acc_r, acc_nxt;
  logic        fnd_r, fnd_nxt;
  logic [8:0]  poc_r, poc_nxt;
  logic [8:0]  lvl_r, lvl_nxt;
  logic        full_r, full_nxt;

  cell_cmd_t   cmd;
  logic [7:0]  cell_data  [CAPACITY];
  logic        cell_valid [CAPACITY];

  logic          in_fire;
  logic          is_full;
  logic          match;
  logic          found_now;
  logic [CW-1:0] pos_now;
  logic [CW-1:0] drop_n;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [7:0] rd;
      logic       rv;
      logic       lv;
      if (gi == CAPACITY - 1) begin : g_last
        assign rd = 8'd0;
        assign rv = 1'b0;
      end else begin : g_mid
        assign rd = cell_data[gi+1];
        assign rv = cell_valid[gi+1];
      end
      if (gi == 0) begin : g_first
        assign lv = 1'b1;
      end else begin : g_rest
        assign lv = cell_valid[gi-1];
      end
      brf_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .head_data   (cell_data[0]),
        .left_valid  (lv),
        .right_data  (rd),
        .right_valid (rv),
        .data_o      (cell_data[gi]),
        .valid_o     (cell_valid[gi])
      );
    end
  endgenerate

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign is_full   = (fill_r == CW'(CAPACITY));
  assign match     = (cell_data[0] == byte_r);
  assign found_now = found_r || match;
  assign pos_now   = found_r ? pos_r : (match ? step_r : '0);
  assign drop_n    = (XW'(in_count) > XW'(fill_r)) ? fill_r : CW'(in_count);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    byte_nxt      = byte_r;
    fill_nxt      = fill_r;
    step_nxt      = step_r;
    target_nxt    = target_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dout_nxt      = dout_r;
    acc_nxt       = acc_r;
    fnd_nxt       = fnd_r;
    poc_nxt       = poc_r;
    lvl_nxt       = lvl_r;
    full_nxt      = full_r;
    cmd.op        = CELL_HOLD;
    cmd.wdata     = in_data_byte;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt      = in_mode;
          byte_nxt      = in_data_byte;
          out_valid_nxt = 1'b1;
          dout_nxt      = 8'd0;
          acc_nxt       = 1'b0;
          fnd_nxt       = 1'b0;
          poc_nxt       = 9'd0;
          lvl_nxt       = 9'(fill_r);
          full_nxt      = is_full;
          case (in_mode)
            MODE_WRITE: begin
              if (!is_full) begin
                cmd.op   = CELL_WRITE;
                fill_nxt = fill_r + CW'(1);
                acc_nxt  = 1'b1;
                lvl_nxt  = 9'(fill_r + CW'(1));
                full_nxt = ((fill_r + CW'(1)) == CW'(CAPACITY));
              end
            end
            MODE_READ: begin
              if (fill_r != '0) begin
                cmd.op   = CELL_SHIFT;
                fill_nxt = fill_r - CW'(1);
                dout_nxt = cell_data[0];
                acc_nxt  = 1'b1;
                lvl_nxt  = 9'(fill_r - CW'(1));
                full_nxt = 1'b0;
              end
            end
            MODE_PEEK: begin
              dout_nxt = cell_data[0];
            end
            MODE_SEARCH, MODE_DROP_UNTIL: begin
              if (fill_r != '0) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_SCAN;
                step_nxt      = '0;
                pos_nxt       = '0;
                found_nxt     = 1'b0;
              end
            end
            MODE_DROP_COUNT: begin
              if (drop_n != '0) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_DROP;
                step_nxt      = '0;
                target_nxt    = drop_n;
                found_nxt     = 1'b0;
              end
            end
            MODE_CLEAR: begin
              cmd.op   = CELL_CLEAR;
              fill_nxt = '0;
              lvl_nxt  = 9'd0;
              full_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        cmd.op   = CELL_ROTATE;
        step_nxt = step_r + CW'(1);
        if (!found_r && match) begin
          found_nxt = 1'b1;
          pos_nxt   = step_r;
        end
        if (step_r == fill_r - CW'(1)) begin
          if (mode_r == MODE_DROP_UNTIL && found_now && pos_now != '0) begin
            state_nxt  = S_DROP;
            step_nxt   = '0;
            target_nxt = pos_now;
            found_nxt  = 1'b1;
          end else begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            dout_nxt      = 8'd0;
            acc_nxt       = 1'b0;
            fnd_nxt       = found_now;
            poc_nxt       = 9'(pos_now);
            lvl_nxt       = 9'(fill_r);
            full_nxt      = is_full;
          end
        end
      end

      S_DROP: begin
        cmd.op   = CELL_SHIFT;
        step_nxt = step_r + CW'(1);
        fill_nxt = fill_r - CW'(1);
        if (step_r == target_r - CW'(1)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          dout_nxt      = 8'd0;
          acc_nxt       = 1'b0;
          fnd_nxt       = found_r;
          poc_nxt       = 9'(target_r);
          lvl_nxt       = 9'(fill_r - CW'(1));
          full_nxt      = 1'b0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    byte_r   <= byte_nxt;
    target_r <= target_nxt;
    pos_r    <= pos_nxt;
    dout_r   <= dout_nxt;
    acc_r    <= acc_nxt;
    fnd_r    <= fnd_nxt;
    poc_r    <= poc_nxt;
    lvl_r    <= lvl_nxt;
    full_r   <= full_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_data_out          = dout_r;
  assign out_accepted          = acc_r;
  assign out_found             = fnd_r;
  assign out_position_or_count = poc_r;
  assign out_fill_level        = lvl_r;
  assign out_full_res          = full_r;

endmodule
